[design/stc_pkg.sv]
// shared constants, types and helpers for the soft timer channel bank
// no dependencies; used by the interfaces and every module of the block
package stc_pkg;

    localparam int CHANNELS   = 32;
    localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COUNT_BITS = 16;
    localparam int CHNUM_W    = 7;
    localparam int GRANT_W    = 6;
    localparam int LIMIT_W    = 8;
    localparam int FUNC_W     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POLL  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

    typedef logic [FUNC_W-1:0]     t_func;
    typedef logic [CHNUM_W-1:0]    t_chnum;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [GRANT_W-1:0]    t_grant;
    typedef logic [LIMIT_W-1:0]    t_limit;
    typedef logic [CHANNELS-1:0]   t_chmask;

    // controller to datapath commands
    typedef struct packed {
        logic latch;    // capture the accepted item
        logic exec;     // apply the item and load the result register
    } t_ctl_cmd;

    typedef struct packed {
        logic               found;
        logic [CH_BITS-1:0] idx;
    } t_free_ch;

    // lowest channel whose used bit is clear
    function automatic t_free_ch find_free(input t_chmask used);
        t_free_ch res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int k = CHANNELS - 1; k >= 0; k--) begin
            if (!used[k]) begin
                res.found = 1'b1;
                res.idx   = CH_BITS'(k);
            end
        end
        return res;
    endfunction

endpackage

[design/stc_if.sv]
// valid/ready channel interfaces for the soft timer channel bank
// depends on stc_pkg for the payload types
interface stc_in_if;
    logic           valid;
    logic           ready;
    stc_pkg::t_func  func;
    stc_pkg::t_chnum channel_number;
    logic           auto_clear;
    stc_pkg::t_count period;

    modport source (output valid, output func, output channel_number,
                    output auto_clear, output period, input ready);
    modport sink   (input valid, input func, input channel_number,
                    input auto_clear, input period, output ready);
endinterface

interface stc_out_if;
    logic           valid;
    logic           ready;
    logic           expired;
    stc_pkg::t_grant granted_channel;

    modport source (output valid, output expired, output granted_channel, input ready);
    modport sink   (input valid, input expired, input granted_channel, output ready);
endinterface

[design/stc_ctrl.sv]
// controller state machine: accepts one transaction, then executes it
// depends on stc_pkg for the command struct
module stc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output stc_pkg::t_ctl_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait until the result register can take the new result
                if (slot_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[design/stc_dp.sv]
// datapath: prescaler, channel bit vectors, step counts and result register
// depends on stc_pkg for widths, codes and the free channel search
module stc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stc_pkg::t_ctl_cmd i_cmd,
    input  logic              i_cfg_we,
    input  stc_pkg::t_limit   i_cfg_wdata,
    input  stc_pkg::t_func    i_func,
    input  stc_pkg::t_chnum   i_channel_number,
    input  logic              i_auto_clear,
    input  stc_pkg::t_count   i_period,
    output logic              o_expired,
    output stc_pkg::t_grant   o_granted_channel
);

    // captured item
    stc_pkg::t_func  r_func;
    stc_pkg::t_chnum r_ch;
    logic            r_auto;
    stc_pkg::t_count r_period;

    stc_pkg::t_limit  r_limit, r_prescale;
    stc_pkg::t_chmask r_pending, n_pending;
    stc_pkg::t_chmask r_in_use, n_in_use;
    stc_pkg::t_chmask r_cnt_vld, n_cnt_vld;   // clear count reads as zero
    stc_pkg::t_count  r_cnt [stc_pkg::CHANNELS];
    logic             r_expired, n_expired;
    stc_pkg::t_grant  r_granted, n_granted;
    stc_pkg::t_limit  n_prescale;

    logic                       ch_ok;
    logic [stc_pkg::CH_BITS-1:0] idx;
    stc_pkg::t_count            cur, inc, nxt;
    logic                       cnt_we;
    stc_pkg::t_free_ch          fr;

    assign ch_ok = r_ch < stc_pkg::t_chnum'(stc_pkg::CHANNELS);
    assign idx   = r_ch[stc_pkg::CH_BITS-1:0];
    assign cur   = r_cnt_vld[idx] ? r_cnt[idx] : '0;
    assign inc   = (cur <= r_period) ? cur + stc_pkg::t_count'(1) : cur;
    assign nxt   = (r_auto && inc >= r_period) ? '0 : inc;
    assign fr    = stc_pkg::find_free(r_in_use);

    always_comb begin
        n_prescale = r_prescale;
        n_pending  = r_pending;
        n_in_use   = r_in_use;
        n_cnt_vld  = r_cnt_vld;
        n_expired  = 1'b0;
        n_granted  = '0;
        cnt_we     = 1'b0;
        unique case (r_func)
            stc_pkg::FUNC_TICK: begin
                if (r_prescale >= r_limit) begin
                    n_prescale = '0;
                    n_pending  = '1;
                end else begin
                    n_prescale = r_prescale + stc_pkg::t_limit'(1);
                end
            end
            stc_pkg::FUNC_ALLOC: begin
                if (fr.found) begin
                    n_in_use[fr.idx]  = 1'b1;
                    n_cnt_vld[fr.idx] = 1'b0;
                    n_granted         = stc_pkg::t_grant'(fr.idx);
                end else begin
                    n_granted = stc_pkg::t_grant'(stc_pkg::CHANNELS);
                end
            end
            stc_pkg::FUNC_POLL: begin
                if (ch_ok) begin
                    n_in_use[idx] = 1'b1;
                    if (r_pending[idx]) begin
                        n_pending[idx] = 1'b0;
                        n_cnt_vld[idx] = 1'b1;
                        n_expired      = (inc == r_period);
                        cnt_we         = 1'b1;
                    end
                end
            end
            stc_pkg::FUNC_CLEAR: begin
                n_pending = '0;
                n_in_use  = '0;
                n_cnt_vld = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= stc_pkg::LIMIT_RESET;
            r_prescale <= '0;
            r_pending  <= '0;
            r_in_use   <= '0;
            r_cnt_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_prescale <= n_prescale;
                r_pending  <= n_pending;
                r_in_use   <= n_in_use;
                r_cnt_vld  <= n_cnt_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func   <= i_func;
            r_ch     <= i_channel_number;
            r_auto   <= i_auto_clear;
            r_period <= i_period;
        end
        if (i_cmd.exec) begin
            r_expired <= n_expired;
            r_granted <= n_granted;
            if (cnt_we) begin
                r_cnt[idx] <= nxt;
            end
        end
    end

    assign o_expired         = r_expired;
    assign o_granted_channel = r_granted;

endmodule

[design/soft_timer_channel_bank.sv]
// top level of the soft timer channel bank: controller plus datapath
// depends on stc_pkg, stc_if, stc_ctrl and stc_dp
//
//   port          dir  handshake     carries
//   i_in          in   valid/ready   func, channel_number, auto_clear, period
//   o_out         out  valid/ready   expired, granted_channel
//   i_cfg_we/..   in   write enable  tick_prescale_limit (8 bits)
//
// each transaction is first captured, then executed against the channel state, which
// loads the result register
// the result register lets the next item be captured while a result waits
// if a result still waits at execute time the controller holds in execute
// synchronous active-low reset clears all channel state, prescaler to zero, limit to 100
module soft_timer_channel_bank (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  stc_pkg::t_limit i_cfg_wdata,
    stc_in_if.sink          i_in,
    stc_out_if.source       o_out
);

    stc_pkg::t_ctl_cmd cmd;

    // sequencing: capture, then execute when the result slot is free
    stc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // channel state and result payload
    stc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_func            (i_in.func),
        .i_channel_number  (i_in.channel_number),
        .i_auto_clear      (i_in.auto_clear),
        .i_period          (i_in.period),
        .o_expired         (o_out.expired),
        .o_granted_channel (o_out.granted_channel)
    );

`ifndef SYNTHESIS
    // a captured item blocks the input until executed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input ready while an item is in flight");

    // execute never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> (!o_out.valid || o_out.ready))
        else $error("result overwritten before transaction");

    // an expired result carries a granted channel of zero
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.expired |-> o_out.granted_channel == '0)
        else $error("expired with a granted channel");
`endif

endmodule
